// ----- hdl/timed_output_step_sequencer_core_macros.svh -----
// Assertion macros for the step sequencer core
`ifndef TIMED_OUTPUT_STEP_SEQUENCER_CORE_MACROS_SVH
`define TIMED_OUTPUT_STEP_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTH
`define TOS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tos assertion failed");
`define TOS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tos assertion failed");
`else
`define TOS_ASSERT_IMPL(label, ante, cons)
`define TOS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hdl/tos_pkg.sv -----
// Types, constants and the pin map of the step sequencer
package tos_pkg;

    localparam int MAX_STEPS_DEF = 16;
    localparam int STEP_W        = 4;
    localparam int CNT_W         = 5;
    localparam int DUR_W         = 17;
    localparam int PIN_W         = 6;
    localparam logic [DUR_W-1:0] TIMER_MAX = '1;

    typedef enum logic [2:0] {
        MODE_LOAD   = 3'd0,
        MODE_START  = 3'd1,
        MODE_STOP   = 3'd2,
        MODE_TICK   = 3'd3,
        MODE_UPDATE = 3'd4
    } t_mode;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [2:0]       mode;
        logic             first_entry;
        logic [3:0]       channel;
        logic             level;
        logic [DUR_W-1:0] duration_ms;
    } t_item;

    typedef struct packed {
        logic [3:0]       channel;
        logic             level;
        logic [DUR_W-1:0] duration_ms;
    } t_step;

    localparam int STEP_BITS = $bits(t_step);

    typedef struct packed {
        logic              fire;
        logic [PIN_W-1:0]  pin;
        logic              drive_level;
        logic [STEP_W-1:0] step_index;
        logic              busy_res;
        logic              done_res;
        logic              bad_channel;
        logic              table_full;
    } t_res;

    // channel -> {bad, pin}; channels outside 1..12 are bad and map to pin 0
    function automatic logic [PIN_W:0] pin_lookup(input logic [3:0] ch);
        logic [PIN_W:0] r;
        case (ch)
            4'd1:    r = {1'b0, 6'd34};
            4'd2:    r = {1'b0, 6'd35};
            4'd3:    r = {1'b0, 6'd36};
            4'd4:    r = {1'b0, 6'd37};
            4'd5:    r = {1'b0, 6'd38};
            4'd6:    r = {1'b0, 6'd39};
            4'd7:    r = {1'b0, 6'd40};
            4'd8:    r = {1'b0, 6'd41};
            4'd9:    r = {1'b0, 6'd17};
            4'd10:   r = {1'b0, 6'd16};
            4'd11:   r = {1'b0, 6'd15};
            4'd12:   r = {1'b0, 6'd14};
            default: r = {1'b1, 6'd0};
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/tos_if.sv -----
// Valid/ready channel interfaces for sequencer items and results
interface tos_item_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic        first_entry;
    logic [3:0]  channel;
    logic        level;
    logic [16:0] duration_ms;

    modport source (output valid, mode, first_entry, channel, level, duration_ms,
                    input ready);
    modport sink   (input valid, mode, first_entry, channel, level, duration_ms,
                    output ready);
endinterface

interface tos_res_if;
    logic       valid;
    logic       ready;
    logic       fire;
    logic [5:0] pin;
    logic       drive_level;
    logic [3:0] step_index;
    logic       busy_res;
    logic       done_res;
    logic       bad_channel;
    logic       table_full;

    modport source (output valid, fire, pin, drive_level, step_index, busy_res,
                    done_res, bad_channel, table_full, input ready);
    modport sink   (input valid, fire, pin, drive_level, step_index, busy_res,
                    done_res, bad_channel, table_full, output ready);
endinterface

// ----- hdl/tos_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module tos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/tos_engine.sv -----
// Sequencer control: run state, timer, and the writes and reads of the step table
`include "timed_output_step_sequencer_core_macros.svh"
module tos_engine import tos_pkg::*; #(
    parameter int MAX_STEPS = MAX_STEPS_DEF,
    parameter int AW        = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_item                i_item,
    input  logic                 i_out_free,
    output logic                 o_res_valid,
    output t_res                 o_res,
    output logic                 o_ram_we,
    output logic [AW-1:0]        o_ram_waddr,
    output t_step                o_ram_wdata,
    output logic [AW-1:0]        o_ram_raddr,
    input  logic [STEP_BITS-1:0] i_ram_rdata
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_STEPS);

    t_state            r_state, n_state;
    t_item             r_item;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [STEP_W-1:0] r_cur, n_cur;
    logic              r_run, n_run;
    logic              r_wait, n_wait;
    logic [DUR_W-1:0]  r_el, n_el;

    t_step             rd_step;
    logic [CNT_W-1:0]  base_cnt;
    logic [CNT_W-1:0]  next_idx;
    logic [PIN_W:0]    lookup;
    logic              accept;

    assign accept      = i_in_valid && o_in_ready;
    assign rd_step     = t_step'(i_ram_rdata);
    assign lookup      = pin_lookup(rd_step.channel);
    // table is always read at the current step; data is valid in ST_EXEC
    assign o_ram_raddr = r_cur[AW-1:0];
    assign base_cnt    = r_item.first_entry ? '0 : r_cnt;
    assign next_idx    = {1'b0, r_cur} + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_cur   <= '0;
            r_run   <= 1'b0;
            r_wait  <= 1'b0;
            r_el    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_cur   <= n_cur;
            r_run   <= n_run;
            r_wait  <= n_wait;
            r_el    <= n_el;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_cur       = r_cur;
        n_run       = r_run;
        n_wait      = r_wait;
        n_el        = r_el;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = base_cnt[AW-1:0];
        o_ram_wdata = '{channel: r_item.channel, level: r_item.level,
                        duration_ms: r_item.duration_ms};
        o_res       = '0;

        unique case (r_state)
            ST_IDLE: begin
                // no transfer while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = ST_IDLE;
                    case (r_item.mode)
                        MODE_LOAD: begin
                            if (r_item.first_entry) begin
                                n_cur  = '0;
                                n_run  = 1'b0;
                                n_wait = 1'b0;
                                n_el   = '0;
                            end
                            if (base_cnt >= MAX_CNT) begin
                                n_cnt            = base_cnt;
                                o_res.table_full = 1'b1;
                            end else begin
                                o_ram_we = 1'b1;
                                n_cnt    = base_cnt + CNT_W'(1);
                            end
                        end
                        MODE_START: begin
                            n_run  = 1'b1;
                            n_cur  = '0;
                            n_el   = '0;
                            n_wait = 1'b0;
                        end
                        MODE_STOP: begin
                            n_run = 1'b0;
                        end
                        MODE_TICK: begin
                            if (r_el != TIMER_MAX) begin
                                n_el = r_el + DUR_W'(1);
                            end
                        end
                        MODE_UPDATE: begin
                            if (r_cnt == '0 || !r_run) begin
                                n_el = '0;
                            end else if (!r_wait) begin
                                o_res.fire        = 1'b1;
                                o_res.drive_level = rd_step.level;
                                o_res.pin         = lookup[PIN_W-1:0];
                                o_res.bad_channel = lookup[PIN_W];
                                n_el              = '0;
                                n_wait            = 1'b1;
                            end else if (r_el >= rd_step.duration_ms) begin
                                n_wait = 1'b0;
                                if (next_idx >= r_cnt) begin
                                    n_cur          = '0;
                                    n_run          = 1'b0;
                                    n_cnt          = '0;
                                    o_res.done_res = 1'b1;
                                end else begin
                                    n_cur = next_idx[STEP_W-1:0];
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    o_res.step_index = n_cur;
                    o_res.busy_res   = n_run;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `TOS_ASSERT_IMPL(a_cnt_bound, 1'b1, r_cnt <= MAX_CNT)
    `TOS_ASSERT_IMPL(a_cur_in_table, r_run && r_cnt != '0, CNT_W'(r_cur) < r_cnt)
    `TOS_ASSERT_IMPL(a_we_on_load, o_ram_we, r_state == ST_EXEC && r_item.mode == MODE_LOAD)
    `TOS_ASSERT_NEXT(a_done_empties, o_res_valid && o_res.done_res, r_cnt == '0 && !r_run)

endmodule

// ----- hdl/timed_output_step_sequencer_core.sv -----
// A result is computed in ST_EXEC once the result register is free, and is
// registered there before it can transfer out.
// The engine takes no new item until the last one has left ST_EXEC; the registered
// table read sits between transfer and the read-modify-write of the run state.
// The result register frees the input side while a result waits downstream.
// Reset (synchronous, active low) clears run state, step count and timer;
// table entries are undefined until loaded and are never read before that.
module timed_output_step_sequencer_core import tos_pkg::*; #(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tos_item_if.sink  i_item,
    tos_res_if.source o_res
);

    localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    t_item                item;
    t_res                 res;
    logic                 res_valid;
    logic                 in_ready;
    logic                 out_free;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [AW-1:0]        ram_raddr;
    t_step                ram_wdata;
    logic [STEP_BITS-1:0] ram_rdata;

    logic r_out_valid;
    t_res r_out;

    assign item = '{mode: i_item.mode, first_entry: i_item.first_entry,
                    channel: i_item.channel, level: i_item.level,
                    duration_ms: i_item.duration_ms};
    assign i_item.ready = in_ready;
    assign out_free     = !r_out_valid || o_res.ready;

    tos_ram #(
        .WIDTH (STEP_BITS),
        .DEPTH (MAX_STEPS),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (STEP_BITS'(ram_wdata)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tos_engine #(
        .MAX_STEPS (MAX_STEPS),
        .AW        (AW)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (in_ready),
        .i_item      (item),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.fire        = r_out.fire;
    assign o_res.pin         = r_out.pin;
    assign o_res.drive_level = r_out.drive_level;
    assign o_res.step_index  = r_out.step_index;
    assign o_res.busy_res    = r_out.busy_res;
    assign o_res.done_res    = r_out.done_res;
    assign o_res.bad_channel = r_out.bad_channel;
    assign o_res.table_full  = r_out.table_full;

endmodule

// ----- dv/timed_output_step_sequencer_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the timed output step sequencer core
module timed_output_step_sequencer_core_tb;
    import tos_pkg::*;

    localparam int LAT_PAD      = 4;     // result is registered after its item is transferred
    localparam int HOLD_CYCLES  = 80;
    localparam int RANDOM_ITEMS = 1230;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int LONG_HOLD    = 200;
    localparam int CH_LO        = 1;
    localparam int CH_HI        = 12;
    localparam int MODE_SPARE_LO = int'(MODE_UPDATE) + 1;
    localparam int MODE_SPARE_HI = 7;
    localparam logic [PIN_W-1:0] CH_PIN [12] = '{
        6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39,
        6'd40, 6'd41, 6'd17, 6'd16, 6'd15, 6'd14
    };
    localparam int IDLE_MIX [5] = '{0, 0, 10, 30, 60};

    logic i_clk = 1'b0;
    logic i_rst_n;

    tos_item_if item_bus ();
    tos_res_if  res_bus ();

    timed_output_step_sequencer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_bus),
        .o_res   (res_bus)
    );

    always #1 i_clk = ~i_clk;

    // sequencer state as the predictor sees it
    logic [3:0]       seq_ch  [16];
    logic             seq_lvl [16];
    logic [DUR_W-1:0] seq_dur [16];
    int               seq_count   = 0;
    int               seq_cur     = 0;
    bit               seq_run     = 1'b0;
    bit               seq_armed   = 1'b0;
    logic [DUR_W-1:0] seq_elapsed = '0;

    t_res step_reports [$];
    int   mismatches  = 0;
    int   items_sent  = 0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    bit   steady      = 1'b0;
    bit   hold_req    = 1'b0;
    int   hold_left   = 0;
    int   stall_left  = 0;
    int   rx_gap;

    task automatic flag_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [16:0] got,
                                 input logic [16:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // advance the predicted state by one item and return the status it reports
    function automatic t_res apply_to_sequencer(input t_item it);
        t_res r;
        r = '0;
        case (it.mode)
            MODE_LOAD: begin
                if (it.first_entry) begin
                    seq_count   = 0;
                    seq_cur     = 0;
                    seq_run     = 1'b0;
                    seq_armed   = 1'b0;
                    seq_elapsed = '0;
                end
                if (seq_count >= MAX_STEPS_DEF) begin
                    r.table_full = 1'b1;
                end else begin
                    seq_ch[seq_count]  = it.channel;
                    seq_lvl[seq_count] = it.level;
                    seq_dur[seq_count] = it.duration_ms;
                    seq_count++;
                end
            end
            MODE_START: begin
                seq_run     = 1'b1;
                seq_cur     = 0;
                seq_elapsed = '0;
                seq_armed   = 1'b0;
            end
            MODE_STOP: begin
                seq_run = 1'b0;
            end
            MODE_TICK: begin
                if (seq_elapsed != TIMER_MAX)
                    seq_elapsed++;
            end
            MODE_UPDATE: begin
                if (seq_count == 0 || !seq_run) begin
                    seq_elapsed = '0;
                end else if (!seq_armed) begin
                    r.fire        = 1'b1;
                    r.drive_level = seq_lvl[seq_cur];
                    if (seq_ch[seq_cur] >= CH_LO && seq_ch[seq_cur] <= CH_HI)
                        r.pin = CH_PIN[seq_ch[seq_cur] - 1];
                    else
                        r.bad_channel = 1'b1;
                    seq_elapsed = '0;
                    seq_armed   = 1'b1;
                end else if (seq_elapsed >= seq_dur[seq_cur]) begin
                    seq_armed = 1'b0;
                    seq_cur++;
                    if (seq_cur >= seq_count) begin
                        seq_cur    = 0;
                        seq_run    = 1'b0;
                        seq_count  = 0;
                        r.done_res = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.step_index = 4'(seq_cur);
        r.busy_res   = seq_run;
        return r;
    endfunction

    // results are checked before the item of the same edge is predicted
    always @(posedge i_clk) begin : check_results
        t_res  want;
        t_item it;
        if (i_rst_n) begin
            if (res_bus.valid && res_bus.ready) begin
                if (step_reports.size() == 0) begin
                    flag_mismatch("result transfer with no item outstanding");
                end else begin
                    want = step_reports.pop_front();
                    compare_field("fire",        res_bus.fire,        want.fire);
                    compare_field("pin",         res_bus.pin,         want.pin);
                    compare_field("drive_level", res_bus.drive_level, want.drive_level);
                    compare_field("step_index",  res_bus.step_index,  want.step_index);
                    compare_field("busy_res",    res_bus.busy_res,    want.busy_res);
                    compare_field("done_res",    res_bus.done_res,    want.done_res);
                    compare_field("bad_channel", res_bus.bad_channel, want.bad_channel);
                    compare_field("table_full",  res_bus.table_full,  want.table_full);
                end
            end
            if (item_bus.valid && item_bus.ready) begin
                it.mode        = item_bus.mode;
                it.first_entry = item_bus.first_entry;
                it.channel     = item_bus.channel;
                it.level       = item_bus.level;
                it.duration_ms = item_bus.duration_ms;
                step_reports.push_back(apply_to_sequencer(it));
            end
        end
    end

    // result side: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            res_bus.ready <= 1'b0;
            hold_left--;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            res_bus.ready <= 1'b0;
        end else if (stall_left > 0) begin
            res_bus.ready <= 1'b0;
            stall_left--;
        end else begin
            rx_gap = steady ? 0 : pick_gap(rx_idle_pct);
            if (rx_gap > 0) begin
                res_bus.ready <= 1'b0;
                stall_left = rx_gap - 1;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input t_item it);
        int gap;
        gap = steady ? 0 : pick_gap(tx_idle_pct);
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_bus.mode        <= it.mode;
        item_bus.first_entry <= it.first_entry;
        item_bus.channel     <= it.channel;
        item_bus.level       <= it.level;
        item_bus.duration_ms <= it.duration_ms;
        item_bus.valid       <= 1'b1;
        do @(posedge i_clk); while (!item_bus.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic load_step(input logic fe, input logic [3:0] ch, input logic lvl,
                             input logic [DUR_W-1:0] dur);
        t_item it;
        it.mode        = MODE_LOAD;
        it.first_entry = fe;
        it.channel     = ch;
        it.level       = lvl;
        it.duration_ms = dur;
        send_item(it);
    endtask

    // non-load item; the unused fields carry random bits
    task automatic issue(input logic [2:0] mode);
        t_item it;
        it.mode        = mode;
        it.first_entry = 1'($urandom);
        it.channel     = 4'($urandom);
        it.level       = 1'($urandom);
        it.duration_ms = DUR_W'($urandom);
        send_item(it);
    endtask

    task automatic settle();
        item_bus.valid <= 1'b0;
        while (step_reports.size() != 0) @(negedge i_clk);
        repeat (LAT_PAD) @(negedge i_clk);
    endtask

    task automatic test_basic_run();
        load_step(1'b1, 4'd1, 1'b1, '0);
        load_step(1'b0, 4'd12, 1'b0, 17'd2);
        issue(MODE_UPDATE);              // not running yet
        issue(MODE_START);
        issue(MODE_UPDATE);              // fire step 0
        issue(MODE_UPDATE);              // zero hold: advance
        issue(MODE_UPDATE);              // fire step 1
        issue(MODE_UPDATE);              // hold not yet elapsed
        issue(MODE_TICK);
        issue(MODE_TICK);
        issue(MODE_UPDATE);              // advance past last step: done
        issue(MODE_UPDATE);              // table emptied on completion
        settle();
    endtask

    task automatic test_bad_channels_and_restart();
        load_step(1'b1, 4'd0, 1'b1, '0);
        load_step(1'b0, 4'd13, 1'b0, '0);
        load_step(1'b0, 4'd15, 1'b1, 17'd99999);
        issue(MODE_START);
        repeat (5) issue(MODE_UPDATE);   // fire, advance, fire, advance, fire
        issue(MODE_TICK);
        issue(MODE_UPDATE);              // long hold still pending
        issue(MODE_STOP);
        issue(MODE_UPDATE);              // stopped: timer cleared only
        issue(MODE_START);               // rewinds and drops the waiting flag
        issue(MODE_UPDATE);
        for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
            issue(3'(m));
        load_step(1'b1, 4'd7, 1'b0, '0); // mid-run reload clears run state
        issue(MODE_UPDATE);
        settle();
    endtask

    task automatic test_table_full();
        for (int k = 0; k < MAX_STEPS_DEF + 2; k++)
            load_step(k == 0, 4'(k), 1'(k), '0);
        issue(MODE_START);
        repeat (2 * MAX_STEPS_DEF) issue(MODE_UPDATE);
        load_step(1'b0, 4'd5, 1'b1, '0); // completion emptied the table
        settle();
    endtask

    task automatic test_back_pressure();
        tx_idle_pct = 0;
        hold_req = 1'b1;
        load_step(1'b1, 4'd3, 1'b1, 17'd1);
        load_step(1'b0, 4'd9, 1'b0, '0);
        issue(MODE_START);
        repeat (27) issue($urandom_range(0, 1) ? MODE_TICK : MODE_UPDATE);
        settle();
    endtask

    task automatic test_long_hold();
        steady = 1'b1;
        load_step(1'b1, 4'd13, 1'b1, DUR_W'(LONG_HOLD));
        issue(MODE_START);
        issue(MODE_UPDATE);
        repeat (LONG_HOLD - 1) issue(MODE_TICK);
        issue(MODE_UPDATE);              // one short of the hold time
        repeat (5) issue(MODE_TICK);
        issue(MODE_UPDATE);
        settle();
        steady = 1'b0;
    endtask

    function automatic logic [DUR_W-1:0] pick_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return DUR_W'($urandom_range(0, 3));
        if (r < 95)
            return DUR_W'($urandom_range(4, 20));
        return DUR_W'($urandom_range(0, int'(TIMER_MAX)));
    endfunction

    function automatic logic [3:0] pick_channel();
        if ($urandom_range(0, 99) < 85)
            return 4'($urandom_range(CH_LO, CH_HI));
        return 4'($urandom);
    endfunction

    // one program load and run, with occasional interference
    task automatic run_program();
        int n;
        int budget;
        int r;
        r = $urandom_range(0, 99);
        n = (r < 70) ? $urandom_range(1, 4) :
            (r < 90) ? $urandom_range(5, 12) : $urandom_range(13, MAX_STEPS_DEF + 2);
        for (int k = 0; k < n; k++)
            load_step(k == 0 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 32) == 0),
                      pick_channel(), 1'($urandom), pick_duration());
        issue(MODE_START);
        budget = n * 12 + 10;
        while (budget > 0) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                issue(MODE_UPDATE);
            else if (r < 82)
                repeat ($urandom_range(1, 3)) issue(MODE_TICK);
            else if (r < 85)
                issue(MODE_STOP);
            else if (r < 88)
                issue(MODE_START);
            else if (r < 92)
                issue(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)));
            else if (r < 95)
                load_step(1'($urandom), 4'($urandom), 1'($urandom), DUR_W'($urandom));
            else
                issue(MODE_UPDATE);
            budget--;
            if (!seq_run && $urandom_range(0, 3) == 0)
                break;
        end
    endtask

    task automatic test_random();
        int base;
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            tx_idle_pct = IDLE_MIX[$urandom_range(0, 4)];
            rx_idle_pct = IDLE_MIX[$urandom_range(0, 4)];
            run_program();
            if ($urandom_range(0, 7) == 0)
                settle();
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        item_bus.valid       = 1'b0;
        item_bus.mode        = MODE_STOP;
        item_bus.first_entry = 1'b0;
        item_bus.channel     = '0;
        item_bus.level       = 1'b0;
        item_bus.duration_ms = '0;
        res_bus.ready        = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_basic_run();
        test_bad_channels_and_restart();
        test_table_full();
        test_back_pressure();
        test_long_hold();
        test_random();

        item_bus.valid <= 1'b0;
        for (int k = 0; k < DRAIN_LIMIT && step_reports.size() != 0; k++)
            @(negedge i_clk);
        repeat (LAT_PAD) @(negedge i_clk);
        if (step_reports.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", step_reports.size()));
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/tos_pkg.sv
hdl/tos_if.sv
hdl/tos_ram.sv
hdl/tos_engine.sv
hdl/timed_output_step_sequencer_core.sv
dv/timed_output_step_sequencer_core_tb.sv
